// File: hdl/ppu_pkg.sv
// Shared constants and types for the particle pool update unit.
package ppu_pkg;
    localparam int SLOTS_DEF = 4096;
    localparam int POS_W = 24;
    localparam int RAD_W = 20;
    localparam int OPA_W = 16;
    localparam int LIFE_W = 16;
    localparam int EDGE_W = 25;
    localparam int SLOT_W = 12;

    typedef enum logic [2:0] {
        ST_SPAWNED = 3'd0,
        ST_FULL    = 3'd1,
        ST_LIFE0   = 3'd2,
        ST_LIVE    = 3'd3,
        ST_EXPIRED = 3'd4,
        ST_IDLE    = 3'd5
    } t_status;

    typedef struct packed {
        logic [23:0] px;
        logic [23:0] py;
        logic [23:0] vx;
        logic [23:0] vy;
        logic [19:0] rad;
        logic [23:0] rgb;
        logic [15:0] opa;
        logic [15:0] life;
    } t_slot;
endpackage

// File: hdl/particle_pool_update_unit.sv
// Top level of the particle pool update unit.
// Update: registered read, two 20-step divides by the stored life, write back, result
// load. Spawn: the free-slot scan tests one slot per cycle from slot 0 up to the lowest
// free slot (all slots if the pool is full), then slot write, result load; life-zero
// spawn and idle-slot update go straight to result load. One item at a time; the next
// item is taken the cycle after the result register loads. Reset clears all in-use flags.
module particle_pool_update_unit #(
    parameter int SLOTS = ppu_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [11:0] i_slot,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_move_x,
    input  logic signed [23:0] i_move_y,
    input  logic [19:0] i_radius_in,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_alpha_in,
    input  logic [15:0] i_life_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [11:0] o_slot_out,
    output logic signed [24:0] o_left_edge,
    output logic signed [24:0] o_right_edge,
    output logic signed [24:0] o_top_edge,
    output logic signed [24:0] o_bottom_edge,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [7:0]  o_alpha_out
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_SCAN  = 9'b0_0000_0010,
        S_RD    = 9'b0_0000_0100,
        S_DIVR  = 9'b0_0000_1000,
        S_DIVO  = 9'b0_0001_0000,
        S_WB    = 9'b0_0010_0000,
        S_SPWR  = 9'b0_0100_0000,
        S_OUT   = 9'b0_1000_0000,
        S_LD    = 9'b1_0000_0000
    } t_state;

    t_state r_state;

    // slot memory, one read port, one write port, registered read
    ppu_pkg::t_slot r_mem [SLOTS];
    ppu_pkg::t_slot r_rd, r_ent;
    logic [AW-1:0]  r_addr;
    logic           r_we;
    ppu_pkg::t_slot r_wd;

    logic [SLOTS-1:0] r_used;

    // free-slot scan, one index per cycle
    logic [AW:0] r_scan;

    logic [2:0]  r_st;
    logic [11:0] r_sl;
    logic        r_full;
    logic [15:0] r_life;

    logic        r_dstart;
    logic [19:0] r_dnum;
    logic [15:0] r_dden;
    logic        w_ddone;
    logic [19:0] w_dquo;

    ppu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dnum), .i_den(r_dden), .o_done(w_ddone), .o_quo(w_dquo)
    );

    always_ff @(posedge i_clk) begin
        if (r_we) r_mem[r_addr] <= r_wd;
        r_rd <= r_mem[r_addr];
    end

    function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [23:0] b);
        logic signed [24:0] s;
        s = $signed({a[23], a}) + $signed({b[23], b});
        if (s > 25'sd8388607) return 24'h7FFFFF;
        if (s < -25'sd8388608) return 24'h800000;
        return s[23:0];
    endfunction

    wire w_acc = i_valid && !o_stall;
    // scan position holds a free slot
    wire w_free = (r_scan != (AW+1)'(SLOTS)) && !r_used[r_scan[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            o_valid <= 1'b0;
            r_we <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            // write strobe on a found slot or at write back
            r_we <= (r_state == S_WB) || (r_state == S_SCAN && w_free);
            // divide kicks: radius after the read, opacity after the radius result
            r_dstart <= (r_state == S_LD) || (r_state == S_DIVR && w_ddone);
            if (o_valid && !i_stall && r_state != S_OUT) o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_full <= 1'b0;
                        r_sl <= i_req_type ? i_slot : 12'd0;
                        r_ent <= '{px: i_pos_x, py: i_pos_y, vx: i_move_x,
                                   vy: i_move_y, rad: i_radius_in,
                                   rgb: {i_red_in, i_green_in, i_blue_in},
                                   opa: {i_alpha_in, i_alpha_in},
                                   life: i_life_in};
                        if (!i_req_type) begin
                            if (i_life_in == 16'd0) begin
                                r_st <= ppu_pkg::ST_LIFE0;
                                r_state <= S_OUT;
                            end else begin
                                r_scan <= '0;
                                r_state <= S_SCAN;
                            end
                        end else if ({20'd0, i_slot} >= 32'(SLOTS) ||
                                     !r_used[AW'(i_slot)]) begin
                            r_st <= ppu_pkg::ST_IDLE;
                            r_state <= S_OUT;
                        end else begin
                            r_addr <= AW'(i_slot);
                            r_state <= S_RD;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_scan == (AW+1)'(SLOTS)) begin
                        r_st <= ppu_pkg::ST_FULL;
                        r_state <= S_OUT;
                    end else if (w_free) begin
                        r_addr <= r_scan[AW-1:0];
                        r_sl <= 12'(r_scan);
                        r_used[r_scan[AW-1:0]] <= 1'b1;
                        r_wd <= r_ent;
                        r_st <= ppu_pkg::ST_SPAWNED;
                        r_full <= 1'b1;
                        r_state <= S_SPWR;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                S_SPWR: r_state <= S_OUT;
                // address registered, read data lands at the end of this cycle
                S_RD: r_state <= S_LD;
                S_LD: begin
                    r_ent <= r_rd;
                    r_life <= (r_rd.life == 16'd0) ? 16'd1 : r_rd.life;
                    r_dnum <= r_rd.rad;
                    r_dden <= (r_rd.life == 16'd0) ? 16'd1 : r_rd.life;
                    r_state <= S_DIVR;
                end
                S_DIVR: begin
                    if (w_ddone) begin
                        r_ent.rad <= r_ent.rad - w_dquo;
                        r_dnum <= 20'hFFFF;
                        r_dden <= r_life;
                        r_state <= S_DIVO;
                    end
                end
                S_DIVO: begin
                    if (w_ddone) begin
                        r_ent.opa <= ({4'd0, r_ent.opa} > w_dquo) ?
                                     r_ent.opa - w_dquo[15:0] : 16'd0;
                        r_ent.px <= sat_add(r_ent.px, r_ent.vx);
                        r_ent.py <= sat_add(r_ent.py, r_ent.vy);
                        r_ent.life <= r_life - 16'd1;
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_wd <= r_ent;
                    r_full <= 1'b1;
                    if (r_ent.life == 16'd0) begin
                        r_used[r_addr] <= 1'b0;
                        r_st <= ppu_pkg::ST_EXPIRED;
                    end else begin
                        r_st <= ppu_pkg::ST_LIVE;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid <= 1'b1;
                        o_status <= r_st;
                        o_slot_out <= r_sl;
                        if (r_full) begin
                            o_left_edge <= $signed({r_ent.px[23], r_ent.px}) -
                                           $signed({5'd0, r_ent.rad});
                            o_right_edge <= $signed({r_ent.px[23], r_ent.px}) +
                                            $signed({5'd0, r_ent.rad});
                            o_top_edge <= $signed({r_ent.py[23], r_ent.py}) -
                                          $signed({5'd0, r_ent.rad});
                            o_bottom_edge <= $signed({r_ent.py[23], r_ent.py}) +
                                             $signed({5'd0, r_ent.rad});
                            o_red_out <= r_ent.rgb[23:16];
                            o_green_out <= r_ent.rgb[15:8];
                            o_blue_out <= r_ent.rgb[7:0];
                            o_alpha_out <= r_ent.opa[15:8];
                        end else begin
                            o_left_edge <= '0;
                            o_right_edge <= '0;
                            o_top_edge <= '0;
                            o_bottom_edge <= '0;
                            o_red_out <= '0;
                            o_green_out <= '0;
                            o_blue_out <= '0;
                            o_alpha_out <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
endmodule

// File: hdl/ppu_div.sv
// Iterative unsigned divider, one quotient bit per cycle.
module ppu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [19:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [19:0] o_quo
);
    logic [19:0] r_quo, n_quo;
    logic [20:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [20:0] w_try;

    always_comb begin
        w_try = {r_rem[19:0], r_quo[19]};
        n_quo = {r_quo[18:0], 1'b0};
        n_rem = w_try;
        if (w_try >= {5'd0, r_den}) begin
            n_rem = w_try - {5'd0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'd20;
                r_quo <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end else if (r_busy) begin
                r_quo <= n_quo;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_quo;
endmodule

// File: test/testbench.sv
// Testbench for the particle pool update unit: self-checking, randomized, with prediction.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = ppu_pkg::SLOTS_DEF;

    // One request item, plus the idling phase it runs in and an optional
    // hold-off until the pool has answered everything before it.
    typedef struct {
        logic        req;
        logic [11:0] slot;
        logic [23:0] px, py, vx, vy;
        logic [19:0] rad;
        logic [7:0]  r, g, b, a;
        logic [15:0] life;
        int          phase;
        bit          drain;
    } t_req;

    typedef struct {
        logic [2:0]  status;
        logic [11:0] slot;
        logic [24:0] left, right, top, bottom;
        logic [7:0]  r, g, b, a;
    } t_quad;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_req_type = 1'b0;
    logic [11:0] i_slot = '0;
    logic signed [23:0] i_pos_x = '0, i_pos_y = '0, i_move_x = '0, i_move_y = '0;
    logic [19:0] i_radius_in = '0;
    logic [7:0]  i_red_in = '0, i_green_in = '0, i_blue_in = '0, i_alpha_in = '0;
    logic [15:0] i_life_in = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [11:0] o_slot_out;
    logic signed [24:0] o_left_edge, o_right_edge, o_top_edge, o_bottom_edge;
    logic [7:0]  o_red_out, o_green_out, o_blue_out, o_alpha_out;

    particle_pool_update_unit dut (.*);

    always #6 i_clk = ~i_clk;

    // Shadow copy of the pool
    bit                 live[NSLOT];
    logic signed [23:0] sh_px[NSLOT], sh_py[NSLOT], sh_vx[NSLOT], sh_vy[NSLOT];
    logic [19:0]        sh_rad[NSLOT];
    logic [23:0]        sh_rgb[NSLOT];
    logic [15:0]        sh_opa[NSLOT];
    logic [15:0]        sh_life[NSLOT];

    t_req  pending[$];
    t_quad quads_due[$];
    t_req  cur;
    bit    rst_done = 0;
    bit    took = 0;
    int    errors = 0;
    int    n_in = 0, n_out = 0;
    int    status_seen[6];
    int    sender_idle, receiver_idle;

    function automatic logic signed [23:0] clamp24(int v);
        if (v > 8388607) return 24'sd8388607;
        if (v < -8388608) return -24'sd8388608;
        return v[23:0];
    endfunction

    function automatic t_quad make_quad(ppu_pkg::t_status st, logic [11:0] s, int i, bit full);
        t_quad q;
        int x, y, rr;
        q = '{default: '0};
        q.status = st;
        q.slot = s;
        if (full) begin
            x = sh_px[i];
            y = sh_py[i];
            rr = int'(sh_rad[i]);
            q.left = 25'(x - rr);
            q.right = 25'(x + rr);
            q.top = 25'(y - rr);
            q.bottom = 25'(y + rr);
            q.r = sh_rgb[i][23:16];
            q.g = sh_rgb[i][15:8];
            q.b = sh_rgb[i][7:0];
            q.a = sh_opa[i][15:8];
        end
        return q;
    endfunction

    // Apply one request to the shadow pool and give back the answer it draws
    function automatic t_quad pool_answer(t_req it);
        int i, lf, dec;
        ppu_pkg::t_status st;
        if (!it.req) begin
            if (it.life == 0) return make_quad(ppu_pkg::ST_LIFE0, '0, 0, 0);
            i = 0;
            while (i < NSLOT && live[i]) i++;
            if (i >= NSLOT) return make_quad(ppu_pkg::ST_FULL, '0, 0, 0);
            sh_px[i] = it.px;
            sh_py[i] = it.py;
            sh_vx[i] = it.vx;
            sh_vy[i] = it.vy;
            sh_rad[i] = it.rad;
            sh_rgb[i] = {it.r, it.g, it.b};
            sh_opa[i] = 16'(it.a * 257);
            sh_life[i] = it.life;
            live[i] = 1;
            return make_quad(ppu_pkg::ST_SPAWNED, 12'(i), i, 1);
        end
        i = it.slot;
        if (i >= NSLOT) return make_quad(ppu_pkg::ST_IDLE, it.slot, 0, 0);
        if (!live[i]) return make_quad(ppu_pkg::ST_IDLE, it.slot, 0, 0);
        lf = (sh_life[i] == 0) ? 1 : sh_life[i];
        sh_px[i] = clamp24(int'(sh_px[i]) + int'(sh_vx[i]));
        sh_py[i] = clamp24(int'(sh_py[i]) + int'(sh_vy[i]));
        sh_rad[i] = sh_rad[i] - 20'(int'(sh_rad[i]) / lf);
        dec = 65535 / lf;
        sh_opa[i] = (int'(sh_opa[i]) > dec) ? 16'(int'(sh_opa[i]) - dec) : 16'd0;
        sh_life[i] = 16'(lf - 1);
        st = ppu_pkg::ST_LIVE;
        if (sh_life[i] == 0) begin
            live[i] = 0;
            st = ppu_pkg::ST_EXPIRED;
        end
        return make_quad(st, it.slot, i, 1);
    endfunction

    task automatic add_spawn(logic [23:0] px, py, vx, vy, logic [19:0] rad,
                             logic [7:0] r, g, b, a, logic [15:0] life,
                             int phase, bit drain = 0);
        t_req it;
        it = '{req: 1'b0, slot: 12'($urandom), px: px, py: py, vx: vx, vy: vy,
               rad: rad, r: r, g: g, b: b, a: a, life: life, phase: phase, drain: drain};
        pending.push_back(it);
    endtask

    task automatic add_update(logic [11:0] s, int phase, bit drain = 0);
        t_req it;
        // payload fields other than slot are don't-care on update; randomize them
        it = '{req: 1'b1, slot: s, px: 24'($urandom), py: 24'($urandom),
               vx: 24'($urandom), vy: 24'($urandom), rad: 20'($urandom),
               r: 8'($urandom), g: 8'($urandom), b: 8'($urandom), a: 8'($urandom),
               life: 16'($urandom), phase: phase, drain: drain};
        pending.push_back(it);
    endtask

    task automatic check_field(string name, logic [24:0] want, logic [24:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
        end
    endtask

    // Idling rates per phase: 1 = sender 37 / receiver 66, 2 = swapped, else none
    function automatic int idle_pct(int phase, bit sender);
        if (phase == 1) return sender ? 37 : 66;
        if (phase == 2) return sender ? 66 : 37;
        return 0;
    endfunction

    // Driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (rst_done) begin
            if (!i_valid || took) begin
                if (pending.size() > 0 && !(pending[0].drain && quads_due.size() != 0) &&
                    $urandom_range(0, 99) >= idle_pct(pending[0].phase, 1)) begin
                    cur = pending.pop_front();
                    receiver_idle = idle_pct(cur.phase, 0);
                    i_valid <= 1'b1;
                    i_req_type <= cur.req;
                    i_slot <= cur.slot;
                    i_pos_x <= cur.px;
                    i_pos_y <= cur.py;
                    i_move_x <= cur.vx;
                    i_move_y <= cur.vy;
                    i_radius_in <= cur.rad;
                    i_red_in <= cur.r;
                    i_green_in <= cur.g;
                    i_blue_in <= cur.b;
                    i_alpha_in <= cur.a;
                    i_life_in <= cur.life;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(0, 99) < receiver_idle);
        end
    end

    // Monitor: accepted items feed the shadow pool, accepted results are checked
    always @(posedge i_clk) begin
        t_quad want;
        took = i_valid && !o_stall && i_rst_n;
        if (took) begin
            quads_due.push_back(pool_answer(cur));
            n_in++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            n_out++;
            if (quads_due.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, status %0d slot %0d",
                         $realtime, o_status, o_slot_out);
            end else begin
                want = quads_due.pop_front();
                if (want.status < 6) status_seen[want.status]++;
                check_field("status", want.status, o_status);
                check_field("slot_out", want.slot, o_slot_out);
                check_field("left_edge", want.left, o_left_edge);
                check_field("right_edge", want.right, o_right_edge);
                check_field("top_edge", want.top, o_top_edge);
                check_field("bottom_edge", want.bottom, o_bottom_edge);
                check_field("red_out", want.r, o_red_out);
                check_field("green_out", want.g, o_green_out);
                check_field("blue_out", want.b, o_blue_out);
                check_field("alpha_out", want.a, o_alpha_out);
            end
        end
    end

    initial begin
        int k, phase;
        logic [15:0] lf;
        receiver_idle = 0;
        // Directed: field extremes and every special case but a full pool
        add_spawn(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 20'hFFFFF,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd3, 0);            // slot 0, saturates up
        add_spawn(24'h800000, 24'h800000, 24'h800000, 24'h800000, 20'hFFFFF,
                  8'h00, 8'h00, 8'h00, 8'h00, 16'd2, 0);            // slot 1, saturates down
        add_spawn(24'h0, 24'h0, 24'h0, 24'h0, 20'h0, 8'h5A, 8'hA5, 8'h3C, 8'h80,
                  16'd0, 0);                                        // life zero
        add_spawn(24'h000100, 24'hFFFF00, 24'h000001, 24'hFFFFFF, 20'h00800,
                  8'h12, 8'h34, 8'h56, 8'hFF, 16'hFFFF, 0);         // slot 2, longest life
        add_spawn(24'h123456, 24'h654321, 24'h0, 24'h0, 20'h00001,
                  8'h01, 8'h02, 8'h03, 8'h01, 16'd1, 0);            // slot 3, single step
        add_update(12'd0, 0);
        add_update(12'd1, 0);                                       // opacity floors at zero
        add_update(12'd1, 0);                                       // expires
        add_update(12'd1, 0);                                       // now idle
        add_update(12'd3, 0);                                       // expires at once
        add_update(12'd2, 0);
        add_update(12'd0, 0);
        add_update(12'd0, 0);
        add_update(12'd4095, 0);                                    // top slot, never used
        add_update(12'd2, 0);
        // Random: spawn/update mixes, mostly on the low slots where slots get reused
        for (k = 0; k < 1385; k++) begin
            phase = (k < 462) ? 1 : (k < 924) ? 2 : 3;
            if ($urandom_range(0, 99) < 45) begin
                case ($urandom_range(0, 9))
                    0: lf = 16'd0;
                    1, 2: lf = 16'($urandom);
                    default: lf = 16'($urandom_range(1, 6));
                endcase
                add_spawn(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          20'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), lf, phase, k == 700);
            end else begin
                add_update(($urandom_range(0, 99) < 85) ? 12'($urandom_range(0, 15))
                                                        : 12'($urandom), phase, k == 700);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rst_done = 1;
        while (pending.size() != 0 || i_valid || quads_due.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Run covered %0d requests and %0d quads: spawned %0d, full %0d, life zero %0d,",
                 n_in, n_out, status_seen[0], status_seen[1], status_seen[2]);
        $display("  updated %0d, expired %0d, idle slot %0d.",
                 status_seen[3], status_seen[4], status_seen[5]);
        if (errors == 0 && quads_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial begin
        #400_000_000;
        $display("Timeout waiting for the pool to answer.");
        $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: sim.f
hdl/ppu_pkg.sv
hdl/ppu_div.sv
hdl/particle_pool_update_unit.sv
test/testbench.sv
